FILE: design/ritoa_pkg.sv
// Shared constants, types and the digit character table for the radix integer-to-ASCII block.
`default_nettype none
package ritoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int NCELLS      = 31;
  localparam int DIGIT_W     = 4;
  localparam int CNT_W       = 5;
  localparam int RADIX_W     = 5;
  localparam int BUFSZ_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + CNT_W + 7) / 8) * 8;
  // extra step at the end so the last cell's flags and carry are visible
  localparam int CONV_CYCLES = VALUE_WIDTH + NCELLS + 1;
  localparam int CYC_W       = $clog2(CONV_CYCLES + 1);

  // token and carry handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic carry;
  } link_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/ritoa_cell.sv
// One digit cell: doubles its digit, adds the incoming carry, reduces modulo the radix.
`default_nettype none
module ritoa_cell
  import ritoa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic [RADIX_W-1:0] radix,
  input  wire logic               used_init,
  input  wire link_t              link_in,
  output link_t                   link_out,
  output logic      [DIGIT_W-1:0] digit,
  output logic                    used
);

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               used_r;
  logic               tok_r;
  logic               carry_r;
  logic [DIGIT_W:0]   sum;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  always_comb begin
    sum  = {digit_r, link_in.carry};
    ge   = (sum >= radix);
    diff = sum - radix;
    digit_nxt = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
      used_r  <= 1'b0;
      tok_r   <= 1'b0;
      carry_r <= 1'b0;
    end else if (clear) begin
      digit_r <= '0;
      used_r  <= used_init;
      tok_r   <= 1'b0;
      carry_r <= 1'b0;
    end else begin
      tok_r   <= link_in.tok;
      carry_r <= link_in.tok & ge;
      if (link_in.tok) begin
        digit_r <= digit_nxt;
        if (link_in.carry) begin
          used_r <= 1'b1;
        end
      end
    end
  end

  assign link_out.tok   = tok_r;
  assign link_out.carry = carry_r;
  assign digit          = digit_r;
  assign used           = used_r;

endmodule
`default_nettype wire

FILE: design/radix_integer_to_ascii.sv
// Top level: radix integer-to-ASCII converter built on a chain of digit cells.
// Flow: an early reject goes from idle to the error state, which loads a single error transaction;
//   a conversion feeds the value bits through the cell chain, then waits for the count check,
//   and its digits are then loaded into the output register one per cycle while it is free.
// The conversion time is set by the skewed bit walk through the 31 cells. One item at a time:
//   no new value is taken until the last transaction of the current one has been loaded.
// Reset: synchronous active-low rst_n; radix returns to 10, buffer_size to 12, no output.
`default_nettype none
module radix_integer_to_ascii
  import ritoa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,    // [31:0] value (signed)
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // [7:0] character, [12:8] digit_count
  output logic                        out_tlast,
  output logic                        out_tuser,   // [0] error
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [7:0]             cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [7:0] REG_RADIX = 8'd0;
  localparam logic [7:0] REG_BUFSZ = 8'd1;

  logic [1:0]             state_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [BUFSZ_W-1:0]     bufsz_r;
  logic [VALUE_WIDTH-1:0] shreg_r;
  logic [CYC_W-1:0]       cyc_r;
  logic [CNT_W-1:0]       ptr_r;     // chases the used-cell boundary -> digit count
  logic [CNT_W-1:0]       idx_r;     // digit being emitted
  logic                   ovf_r;     // carry fell off the top cell

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tvalid_r;
  logic                   out_tlast_r;
  logic                   out_tuser_r;

  link_t                  link_a  [NCELLS+1];
  logic [DIGIT_W-1:0]     digit_a [NCELLS];
  logic [NCELLS-1:0]      used_a;

  logic in_acc;
  logic bad_req;
  logic feeding;
  logic ptr_more;
  logic conv_done;
  logic too_long;
  logic out_free;
  logic out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;
  // output register takes a new transaction this cycle
  assign out_load  = out_free && ((state_r == ST_EMIT) || (state_r == ST_ERR));

  // early rejects: bad base, tiny buffer, negative value
  assign bad_req = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(16)) ||
                   (bufsz_r < BUFSZ_W'(2)) || in_tdata[VALUE_WIDTH-1];

  // value bits go in MSB first, one per cycle, into cell 0
  assign feeding        = (state_r == ST_CONV) && (cyc_r < CYC_W'(VALUE_WIDTH));
  assign link_a[0].tok   = feeding;
  assign link_a[0].carry = feeding & shreg_r[VALUE_WIDTH-1];

  genvar g;
  generate
    for (g = 0; g < NCELLS; g++) begin : g_cell
      ritoa_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (in_acc),
        .radix     (radix_r),
        .used_init ((g == 0) ? 1'b1 : 1'b0),
        .link_in   (link_a[g]),
        .link_out  (link_a[g+1]),
        .digit     (digit_a[g]),
        .used      (used_a[g])
      );
    end
  endgenerate

  // used cells form a prefix; the pointer walks up it one cell per cycle
  assign ptr_more  = (ptr_r != CNT_W'(NCELLS)) && used_a[ptr_r];
  assign conv_done = (cyc_r == CYC_W'(CONV_CYCLES)) && !ptr_more;
  assign too_long  = ovf_r || ({1'b0, ptr_r} >= bufsz_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_W'(10);
      bufsz_r <= BUFSZ_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX: radix_r <= cfg_data[RADIX_W-1:0];
        REG_BUFSZ: bufsz_r <= cfg_data[BUFSZ_W-1:0];
        default:   ;
      endcase
    end
  end

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cyc_r        <= '0;
      ptr_r        <= '0;
      idx_r        <= '0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            shreg_r <= in_tdata[VALUE_WIDTH-1:0];
            cyc_r   <= '0;
            ptr_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= bad_req ? ST_ERR : ST_CONV;
          end
        end
        ST_CONV: begin
          if (feeding) begin
            shreg_r <= {shreg_r[VALUE_WIDTH-2:0], 1'b0};
          end
          if (cyc_r != CYC_W'(CONV_CYCLES)) begin
            cyc_r <= cyc_r + CYC_W'(1);
          end
          if (ptr_more) begin
            ptr_r <= ptr_r + CNT_W'(1);
          end
          if (link_a[NCELLS].carry) begin
            ovf_r <= 1'b1;
          end
          if (conv_done) begin
            idx_r   <= ptr_r - CNT_W'(1);
            state_r <= too_long ? ST_ERR : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= OUT_TDATA_W'({ptr_r, digit_char(digit_a[idx_r])});
            out_tlast_r  <= (idx_r == '0);
            out_tuser_r  <= 1'b0;
            idx_r        <= idx_r - CNT_W'(1);
            if (idx_r == '0) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= '0;
            out_tlast_r  <= 1'b1;
            out_tuser_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // an accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CONV) || (state_r == ST_ERR))
    else $error("accepted item did not start work");

  // emitting only with a digit count that fits the buffer
  a_emit_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ptr_r != '0) && ({1'b0, ptr_r} < bufsz_r) && (idx_r < ptr_r))
    else $error("emit with bad digit count or index");

  // an error transaction is always a single, final one
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast && (out_tdata == '0))
    else $error("error transaction not final or not zero");

  // cell 0 always counts as a digit during conversion
  a_cell0_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> used_a[0])
    else $error("lowest digit cell not marked used");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for radix_integer_to_ascii: directed table, then random values and settings.
module testbench;
  import ritoa_pkg::IN_TDATA_W;
  import ritoa_pkg::OUT_TDATA_W;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  // A conversion walks the cell chain before its first digit, then emits up to 31 digits.
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 500;
  localparam int MAX_GAP       = 12;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 25;

  // register map of the configuration channel
  localparam bit [7:0] REG_RADIX       = 8'd0;
  localparam bit [7:0] REG_BUFFER_SIZE = 8'd1;

  // one character transaction on the result side
  typedef struct packed {
    bit [7:0] ch;
    bit       last;
    bit       err;
    bit [4:0] count;
  } digit_t;

  localparam digit_t ERROR_RESULT = {8'h00, 1'b1, 1'b1, 5'd0};

  typedef struct packed {
    bit [7:0] index;
    bit [7:0] data;
  } reg_write_t;

  // One directed row: raw register bytes (upper bits are dropped by the block),
  // the value, and a typed-in result where it is a single transaction.
  typedef struct packed {
    bit [7:0]  radix_byte;
    bit [7:0]  bsize_byte;
    bit [31:0] value;
    bit        known;
    bit        exp_err;
    bit [7:0]  exp_char;
    bit [4:0]  exp_count;
  } vector_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_index;
  logic [7:0]             cfg_data;

  // mirror of the block's registers, as seen by the predictor
  bit [4:0]   radix_cfg = 5'd10;
  bit [5:0]   bsize_cfg = 6'd12;

  digit_t     expected_digits[$];
  reg_write_t pending_writes[$];
  int         mismatches  = 0;
  int         in_gap_max  = MAX_GAP;
  bit         stall_req   = 1'b0;
  bit         stall_done  = 1'b0;

  vector_t directed_table [26] = '{
    // reset setting: base 10, buffer 12
    {8'd10, 8'd12, 32'd0,          1'b1, 1'b0, "0",   5'd1},
    {8'd10, 8'd12, 32'h7fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    {8'd10, 8'd12, 32'hffffffff,   1'b1, 1'b1, 8'h00, 5'd0},  // negative
    {8'd10, 8'd12, 32'h80000000,   1'b1, 1'b1, 8'h00, 5'd0},  // most negative
    {8'd10, 8'd12, 32'd1,          1'b1, 1'b0, "1",   5'd1},
    // ten digits fit in 11 but not in 10 (terminator needs a slot)
    {8'd10, 8'd11, 32'h7fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    {8'd10, 8'd10, 32'h7fffffff,   1'b1, 1'b1, 8'h00, 5'd0},
    {8'd10, 8'd10, 32'd999999999,  1'b0, 1'b0, 8'h00, 5'd0},
    // smallest usable buffer holds one digit
    {8'd10, 8'd2,  32'd9,          1'b1, 1'b0, "9",   5'd1},
    {8'd10, 8'd2,  32'd10,         1'b1, 1'b1, 8'h00, 5'd0},
    // buffer too small at all
    {8'd10, 8'd1,  32'd0,          1'b1, 1'b1, 8'h00, 5'd0},
    {8'd10, 8'd0,  32'd0,          1'b1, 1'b1, 8'h00, 5'd0},
    // binary: the longest conversion, 31 digits
    {8'd2,  8'd32, 32'h7fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    {8'd2,  8'd32, 32'd0,          1'b1, 1'b0, "0",   5'd1},
    {8'd2,  8'd32, 32'h55555555,   1'b0, 1'b0, 8'h00, 5'd0},
    {8'd2,  8'd31, 32'h7fffffff,   1'b1, 1'b1, 8'h00, 5'd0},
    {8'd2,  8'd31, 32'h3fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    // hex: letter digits
    {8'd16, 8'd12, 32'h7fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    {8'd16, 8'd12, 32'd15,         1'b1, 1'b0, "f",   5'd1},
    {8'd16, 8'd12, 32'h0abcdef9,   1'b0, 1'b0, 8'h00, 5'd0},
    // bases out of range, and one valid base 3 row
    {8'd17, 8'd12, 32'd5,          1'b1, 1'b1, 8'h00, 5'd0},
    {8'd1,  8'd12, 32'd5,          1'b1, 1'b1, 8'h00, 5'd0},
    {8'd0,  8'd12, 32'd0,          1'b1, 1'b1, 8'h00, 5'd0},
    {8'd31, 8'd32, 32'd0,          1'b1, 1'b1, 8'h00, 5'd0},
    {8'd3,  8'd32, 32'h7fffffff,   1'b0, 1'b0, 8'h00, 5'd0},
    // upper write data bits are dropped: base 16, buffer 8
    {8'hf0, 8'hc8, 32'h01234567,   1'b0, 1'b0, 8'h00, 5'd0}
  };

  radix_integer_to_ascii i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Works out the digit transactions one value gives under the current
  // settings and queues them, most significant digit first.
  function automatic void predict_conversion(input bit [31:0] value);
    bit [7:0]  chars[$];
    bit [31:0] rest;
    bit [3:0]  d;
    bit [7:0]  c;
    bit [4:0]  n;
    if (radix_cfg < 2 || radix_cfg > 16 || value[31] || bsize_cfg < 2) begin
      expected_digits.push_back(ERROR_RESULT);
      return;
    end
    rest = value;
    do begin
      d = 4'(rest % radix_cfg);
      c = (d < 4'd10) ? 8'h30 + d : 8'h61 + (d - 4'd10);
      chars.push_front(c);
      rest = rest / radix_cfg;
    end while (rest != 0);
    // room is needed for the terminator as well
    if (chars.size() >= bsize_cfg) begin
      expected_digits.push_back(ERROR_RESULT);
      return;
    end
    n = 5'(chars.size());
    foreach (chars[k])
      expected_digits.push_back({chars[k], k == chars.size() - 1, 1'b0, n});
  endfunction

  // Offers one value after a random gap; returns in the step of the transaction.
  // valid stays high when the next value follows without a gap.
  task automatic send_value(input bit [31:0] value);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Back-to-back register writes from pending_writes; the mirror follows
  // each transaction.
  task automatic write_registers();
    reg_write_t w;
    if (pending_writes.size() == 0)
      return;
    cfg_valid <= 1'b1;
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_index <= w.index;
      cfg_data  <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (w.index == REG_RADIX)
        radix_cfg = w.data[4:0];
      else if (w.index == REG_BUFFER_SIZE)
        bsize_cfg = w.data[5:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops offering and waits until every queued digit has come out, then
  // lets the block settle so that nothing is in flight.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random hold-off per transaction, with runs of no hold-off,
  // and one long hold while stall_req is up so that the block backs up.
  initial begin : result_sink
    int     gap;
    bit     no_idle;
    digit_t e;
    out_tready = 1'b0;
    no_idle    = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0)
        no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall_req && !stall_done) begin
        gap        = LONG_HOLD;
        stall_done = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction char %h err %b",
                                  out_tdata[7:0], out_tuser));
      end else begin
        e = expected_digits.pop_front();
        if (out_tdata[7:0] != e.ch)
          report_mismatch($sformatf("character %h, want %h", out_tdata[7:0], e.ch));
        if (out_tlast != e.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, e.last));
        if (out_tuser != e.err)
          report_mismatch($sformatf("error %b, want %b", out_tuser, e.err));
        if (out_tdata[12:8] != e.count)
          report_mismatch($sformatf("digit count %0d, want %0d", out_tdata[12:8], e.count));
      end
    end
  end

  initial begin : stimulus
    vector_t    vec;
    bit [31:0]  value;
    bit [7:0]   junk_index;
    bit [7:0]   junk_data;
    bit [4:0]   new_radix;
    bit [5:0]   new_bsize;
    bit [2:0]   radix_pad;
    bit [1:0]   bsize_pad;
    int         pick;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: settings change only when a row asks for a new one,
    // and only once the block has gone quiet.
    in_gap_max = MAX_GAP;
    foreach (directed_table[i]) begin
      vec = directed_table[i];
      if (vec.radix_byte[4:0] != radix_cfg || vec.bsize_byte[5:0] != bsize_cfg) begin
        drain_results();
        if (vec.radix_byte[4:0] != radix_cfg)
          pending_writes.push_back({REG_RADIX, vec.radix_byte});
        if (vec.bsize_byte[5:0] != bsize_cfg)
          pending_writes.push_back({REG_BUFFER_SIZE, vec.bsize_byte});
        write_registers();
      end
      send_value(vec.value);
      if (vec.known)
        expected_digits.push_back({vec.exp_char, 1'b1, vec.exp_err, vec.exp_count});
      else
        predict_conversion(vec.value);
    end

    // Random part: each phase drains, picks new settings (mostly valid bases,
    // mostly roomy buffers) and sends a batch of values.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      if ($urandom_range(0, 1)) begin
        // writes to unmapped indexes must leave both registers alone
        junk_index = 8'($urandom_range(2, 255));
        junk_data  = 8'($urandom);
        pending_writes.push_back({junk_index, junk_data});
      end
      pick      = $urandom_range(0, 9);
      new_radix = (pick < 8) ? 5'($urandom_range(2, 16)) : 5'($urandom_range(0, 31));
      pick      = $urandom_range(0, 9);
      new_bsize = (pick < 5) ? 6'd32 :
                  (pick < 8) ? 6'($urandom_range(2, 32)) : 6'($urandom_range(0, 63));
      radix_pad = 3'($urandom);
      bsize_pad = 2'($urandom);
      pending_writes.push_back({REG_RADIX, radix_pad, new_radix});
      pending_writes.push_back({REG_BUFFER_SIZE, bsize_pad, new_bsize});
      write_registers();

      // some phases stream without gaps on the input side
      in_gap_max = (phase % 3 == 0) ? 0 : MAX_GAP;
      stall_req  = (phase == 4);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          value = $urandom | 32'h80000000;
        else if (pick == 1)
          value = $urandom_range(0, 16);
        else
          value = $urandom >> $urandom_range(1, 31);
        send_value(value);
        predict_conversion(value);
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #(CLK_PERIOD * 600000);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
design/ritoa_pkg.sv
design/ritoa_cell.sv
design/radix_integer_to_ascii.sv
tb/testbench.sv
